@@ sv/vstk_pkg.sv @@
// Types and constants shared by the value stack cells and the core.
// No dependencies.
package vstk_pkg;

	// Wide enough for any stack position, level or count in the supported depth range.
	localparam int POS_W = 8;

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [3:0] {
		M_PUSH   = 4'd0,
		M_POP    = 4'd1,
		M_PEEK   = 4'd2,
		M_READN  = 4'd3,
		M_POPN   = 4'd4,
		M_DUP    = 4'd5,
		M_DEL    = 4'd6,
		M_SWAP   = 4'd7,
		M_ROLLDN = 4'd8,
		M_ROLLUP = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_GROUP
	} state_t;

	typedef struct packed {
		mode_t        mode;
		logic [31:0]  push_value;
		logic [5:0]   count;
	} cmd_t;

	typedef struct packed {
		logic [31:0]  value;
		logic         has_value;
		status_t      status;
		logic         last;
		logic [5:0]   level;
	} result_t;

	// Broadcast to every cell: one load slot and two shift windows.
	typedef struct packed {
		logic  ld_en;
		pos_t  ld_pos;
		logic  up_en;   // take the word of the cell above
		pos_t  up_lo;
		pos_t  up_hi;
		logic  dn_en;   // take the word of the cell below
		pos_t  dn_lo;
		pos_t  dn_hi;
	} cell_ctl_t;

endpackage

@@ sv/vstk_cell.sv @@
// One stack slot: holds a word and loads it, or takes a neighbor's word, under the
// broadcast control. Depends on vstk_pkg.
module vstk_cell import vstk_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic [VALUE_WIDTH-1:0] ld_data,
	input  logic [VALUE_WIDTH-1:0] from_below,
	input  logic [VALUE_WIDTH-1:0] from_above,
	output logic [VALUE_WIDTH-1:0] word
);

	localparam pos_t MY_POS = pos_t'(INDEX);

	logic [VALUE_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_en && ctl.ld_pos == MY_POS) begin
			word_q <= ld_data;
		end else if (ctl.up_en && MY_POS >= ctl.up_lo && MY_POS <= ctl.up_hi) begin
			word_q <= from_above;
		end else if (ctl.dn_en && MY_POS >= ctl.dn_lo && MY_POS <= ctl.dn_hi) begin
			word_q <= from_below;
		end
	end

	assign word = word_q;

endmodule

@@ sv/value_stack_with_pick_and_roll_core.sv @@
// Value stack with pick and roll: a row of word cells (bottom in cell 0) under a small sequencer.
// Single-result commands: result strobe in the cycle after the transfer, busy stays low, one per cycle.
// Read top n / pop n with n >= 1: busy while the group state emits; results follow one per cycle,
// each one registered before it shows; the single read select over the cells sets this.
// Reset clears the fill level, the sequencer and the strobe; cell contents stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle.
module value_stack_with_pick_and_roll_core import vstk_pkg::*; #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    result_strobe,
	output result_t result
);

	localparam int   LVL_W     = $clog2(STACK_DEPTH + 1);
	localparam pos_t DEPTH_POS = pos_t'(STACK_DEPTH);

	// Sequencer state
	state_t            state_q, state_d;
	logic [LVL_W-1:0]  level_q, level_d;
	pos_t              ptr_q, ptr_d;       // next cell to emit in a group read
	pos_t              end_q, end_d;       // top cell of the group
	result_t           res_q, res_d;
	logic              strobe_q, strobe_d;

	// Cell row
	logic [VALUE_WIDTH-1:0] word [STACK_DEPTH];
	cell_ctl_t              ctl;
	logic                   ld_sel_rd;     // load from the read select instead of push data
	logic [VALUE_WIDTH-1:0] ld_data;
	logic [VALUE_WIDTH-1:0] push_word;
	pos_t                   rd_pos;
	logic [VALUE_WIDTH-1:0] rd_word;
	logic [31:0]            rd_value;

	logic accept;
	pos_t f, c;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign push_word = VALUE_WIDTH'(cmd.push_value);
	assign ld_data   = ld_sel_rd ? rd_word : push_word;
	assign rd_value  = 32'(rd_word);
	assign f         = pos_t'(level_q);
	assign c         = pos_t'(cmd.count);

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [VALUE_WIDTH-1:0] below, above;
			if (gi == 0) begin : g_bot
				assign below = '0;
			end else begin : g_mid_b
				assign below = word[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_top
				assign above = '0;
			end else begin : g_mid_a
				assign above = word[gi+1];
			end
			vstk_cell #(
				.VALUE_WIDTH (VALUE_WIDTH),
				.INDEX       (gi)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.ld_data    (ld_data),
				.from_below (below),
				.from_above (above),
				.word       (word[gi])
			);
		end
	endgenerate

	// One-hot read select over the row
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (rd_pos == pos_t'(i)) begin
				rd_word = rd_word | word[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			level_q  <= '0;
			ptr_q    <= '0;
			end_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			level_q  <= level_d;
			ptr_q    <= ptr_d;
			end_q    <= end_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		ptr_d     = ptr_q;
		end_d     = end_q;
		ctl       = '0;
		ld_sel_rd = 1'b0;
		rd_pos    = ptr_q;
		strobe_d  = 1'b0;
		res_d     = '0;
		res_d.status = STS_OK;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					strobe_d   = 1'b1;
					res_d.last = 1'b1;
					unique case (cmd.mode) inside
						M_PUSH: begin
							if (f >= DEPTH_POS) begin
								res_d.status = STS_OVERFLOW;
							end else begin
								ctl.ld_en  = 1'b1;
								ctl.ld_pos = f;
								level_d    = LVL_W'(f + 8'd1);
							end
						end
						M_POP: begin
							if (f < 8'd1) begin
								res_d.status = STS_UNDERFLOW;
							end else begin
								rd_pos          = f - 8'd1;
								res_d.value     = rd_value;
								res_d.has_value = 1'b1;
								level_d         = LVL_W'(f - 8'd1);
							end
						end
						M_PEEK: begin
							if (f < c + 8'd1) begin
								res_d.status = STS_UNDERFLOW;
							end else begin
								rd_pos          = f - 8'd1 - c;
								res_d.value     = rd_value;
								res_d.has_value = 1'b1;
							end
						end
						M_READN, M_POPN: begin
							if (f < c) begin
								res_d.status = STS_UNDERFLOW;
							end else if (c != '0) begin
								// results come from the group state, deepest first
								strobe_d = 1'b0;
								ptr_d    = f - c;
								end_d    = f - 8'd1;
								state_d  = S_GROUP;
								if (cmd.mode == M_POPN) begin
									level_d = LVL_W'(f - c);
								end
							end
						end
						M_DUP: begin
							if (f < c + 8'd1) begin
								res_d.status = STS_UNDERFLOW;
							end else if (f >= DEPTH_POS) begin
								res_d.status = STS_OVERFLOW;
							end else begin
								rd_pos          = f - 8'd1 - c;
								ld_sel_rd       = 1'b1;
								ctl.ld_en       = 1'b1;
								ctl.ld_pos      = f;
								res_d.value     = rd_value;
								res_d.has_value = 1'b1;
								level_d         = LVL_W'(f + 8'd1);
							end
						end
						M_DEL: begin
							if (f < c + 8'd1) begin
								res_d.status = STS_UNDERFLOW;
							end else begin
								// cells from the gap up to the old top close down by one
								ctl.up_en = 1'b1;
								ctl.up_lo = f - 8'd1 - c;
								ctl.up_hi = f - 8'd1;
								level_d   = LVL_W'(f - 8'd1);
							end
						end
						M_SWAP: begin
							if (f < 8'd2) begin
								res_d.status = STS_UNDERFLOW;
							end else begin
								ctl.dn_en = 1'b1;
								ctl.dn_lo = f - 8'd1;
								ctl.dn_hi = f - 8'd1;
								ctl.up_en = 1'b1;
								ctl.up_lo = f - 8'd2;
								ctl.up_hi = f - 8'd2;
							end
						end
						M_ROLLDN: begin
							if (f < c) begin
								res_d.status = STS_UNDERFLOW;
							end else if (c >= 8'd2) begin
								// group moves up one, old top wraps to the group bottom
								rd_pos     = f - 8'd1;
								ld_sel_rd  = 1'b1;
								ctl.ld_en  = 1'b1;
								ctl.ld_pos = f - c;
								ctl.dn_en  = 1'b1;
								ctl.dn_lo  = f - c + 8'd1;
								ctl.dn_hi  = f - 8'd1;
							end
						end
						M_ROLLUP: begin
							if (f < c) begin
								res_d.status = STS_UNDERFLOW;
							end else if (c >= 8'd2) begin
								// group moves down one, group bottom wraps to the top
								rd_pos     = f - c;
								ld_sel_rd  = 1'b1;
								ctl.ld_en  = 1'b1;
								ctl.ld_pos = f - 8'd1;
								ctl.up_en  = 1'b1;
								ctl.up_lo  = f - c;
								ctl.up_hi  = f - 8'd2;
							end
						end
						default: begin
							// unused modes: plain ok result, no change
						end
					endcase
				end
			end
			S_GROUP: begin
				rd_pos          = ptr_q;
				strobe_d        = 1'b1;
				res_d.value     = rd_value;
				res_d.has_value = 1'b1;
				res_d.last      = (ptr_q == end_q);
				ptr_d           = ptr_q + 8'd1;
				if (ptr_q == end_q) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.level = 6'(level_d);
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule

@@ dv/value_stack_with_pick_and_roll_core_tb.sv @@
// Self-checking bench for value_stack_with_pick_and_roll_core: a directed table, then random
// command streams, each result compared against hand-typed values or a shadow stack kept in the bench.
// Depends on vstk_pkg and the core RTL.
module value_stack_with_pick_and_roll_core_tb;
	import vstk_pkg::*;

	localparam int DEPTH        = 32;
	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 200000;

	// One row of the directed table: a command and, where it is obvious,
	// the single result typed in by hand.
	typedef struct {
		cmd_t    cmd;
		bit      typed;
		result_t res;
	} step_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    result_strobe;
	result_t result;

	// Shadow copy of the stack; index 0 is the bottom.
	logic [31:0] shadow_word [DEPTH];
	int unsigned shadow_fill;

	result_t   new_results[$];    // results of the command just transferred
	result_t   pending_results[$];
	step_row_t directed_steps[$];
	bit        growing;           // random stream drifts toward full or toward empty
	int        mismatch_count;
	int        cycles;

	value_stack_with_pick_and_roll_core #(
		.STACK_DEPTH(DEPTH),
		.VALUE_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void emit(logic [31:0] v, logic hv, status_t st, logic fin);
		result_t r;
		r = '{value: v, has_value: hv, status: st, last: fin, level: 6'(shadow_fill)};
		new_results.insert(new_results.size(), r);
	endfunction

	// Apply one command to the shadow stack and collect the results it yields.
	function automatic void stack_apply(cmd_t c);
		int unsigned f;
		int unsigned n;
		int unsigned base;
		logic [31:0] w;
		bit          short_stack;
		f = shadow_fill;
		n = c.count;
		new_results.delete();
		// underflow check first; a failing command changes nothing
		case (c.mode)
			M_POP:                           short_stack = f < 1;
			M_PEEK, M_DUP, M_DEL:            short_stack = f < n + 1;
			M_READN, M_POPN, M_ROLLDN, M_ROLLUP: short_stack = f < n;
			M_SWAP:                          short_stack = f < 2;
			default:                         short_stack = 1'b0;
		endcase
		if (short_stack) begin
			emit('0, 1'b0, STS_UNDERFLOW, 1'b1);
			return;
		end
		case (c.mode)
			M_PUSH: begin
				if (f >= DEPTH) begin
					emit('0, 1'b0, STS_OVERFLOW, 1'b1);
				end else begin
					shadow_word[f] = c.push_value;
					shadow_fill = f + 1;
					emit('0, 1'b0, STS_OK, 1'b1);
				end
			end
			M_POP: begin
				w = shadow_word[f-1];
				shadow_fill = f - 1;
				emit(w, 1'b1, STS_OK, 1'b1);
			end
			M_PEEK: emit(shadow_word[f-1-n], 1'b1, STS_OK, 1'b1);
			M_READN, M_POPN: begin
				if (n == 0) begin
					emit('0, 1'b0, STS_OK, 1'b1);
				end else begin
					// deepest first; level reported is the level after the whole command
					base = f - n;
					if (c.mode == M_POPN)
						shadow_fill = base;
					for (int unsigned i = 0; i < n; i++)
						emit(shadow_word[base+i], 1'b1, STS_OK, i + 1 == n);
				end
			end
			M_DUP: begin
				// full test only after the depth test
				if (f >= DEPTH) begin
					emit('0, 1'b0, STS_OVERFLOW, 1'b1);
				end else begin
					w = shadow_word[f-1-n];
					shadow_word[f] = w;
					shadow_fill = f + 1;
					emit(w, 1'b1, STS_OK, 1'b1);
				end
			end
			M_DEL: begin
				for (int unsigned i = f - 1 - n; i + 1 < f; i++)
					shadow_word[i] = shadow_word[i+1];
				shadow_fill = f - 1;
				emit('0, 1'b0, STS_OK, 1'b1);
			end
			M_SWAP: begin
				w = shadow_word[f-1];
				shadow_word[f-1] = shadow_word[f-2];
				shadow_word[f-2] = w;
				emit('0, 1'b0, STS_OK, 1'b1);
			end
			M_ROLLDN: begin
				// top goes to the bottom of the group; groups under 2 stay put
				if (n >= 2) begin
					base = f - n;
					w = shadow_word[f-1];
					for (int unsigned i = f - 1; i > base; i--)
						shadow_word[i] = shadow_word[i-1];
					shadow_word[base] = w;
				end
				emit('0, 1'b0, STS_OK, 1'b1);
			end
			M_ROLLUP: begin
				// bottom of the group comes to the top
				if (n >= 2) begin
					base = f - n;
					w = shadow_word[base];
					for (int unsigned i = base; i + 1 < f; i++)
						shadow_word[i] = shadow_word[i+1];
					shadow_word[f-1] = w;
				end
				emit('0, 1'b0, STS_OK, 1'b1);
			end
			default: emit('0, 1'b0, STS_OK, 1'b1);  // unused mode codes are no-ops
		endcase
	endfunction

	// Random command drawn against the current shadow level. Most counts are
	// in range so the stack really moves; a tenth are arbitrary and mostly underflow.
	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned f;
		int unsigned r;
		f = shadow_fill;
		// linger a few commands at full and at empty so overflow and underflow get hit
		if (f >= DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (f == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		r = $urandom_range(0, 99);
		if (growing) begin
			if (r < 50)      c.mode = M_PUSH;
			else if (r < 60) c.mode = M_DUP;
			else if (r < 70) c.mode = M_PEEK;
			else if (r < 78) c.mode = M_READN;
			else if (r < 84) c.mode = M_SWAP;
			else if (r < 90) c.mode = M_ROLLDN;
			else if (r < 96) c.mode = M_ROLLUP;
			else if (r < 98) c.mode = mode_t'(4'($urandom_range(10, 15)));
			else             c.mode = M_POP;
		end else begin
			if (r < 30)      c.mode = M_POP;
			else if (r < 42) c.mode = M_POPN;
			else if (r < 52) c.mode = M_DEL;
			else if (r < 62) c.mode = M_PEEK;
			else if (r < 70) c.mode = M_READN;
			else if (r < 78) c.mode = M_SWAP;
			else if (r < 84) c.mode = M_ROLLDN;
			else if (r < 90) c.mode = M_ROLLUP;
			else if (r < 93) c.mode = mode_t'(4'($urandom_range(10, 15)));
			else             c.mode = M_PUSH;
		end
		case ($urandom_range(0, 9))
			0:       c.push_value = '0;
			1:       c.push_value = '1;
			default: c.push_value = $urandom;
		endcase
		if ($urandom_range(0, 9) == 0)
			c.count = 6'($urandom_range(0, DEPTH));
		else if (c.mode inside {M_PEEK, M_DUP, M_DEL})
			c.count = 6'($urandom_range(0, f > 0 ? f - 1 : 0));
		else
			c.count = 6'($urandom_range(0, f));
		return c;
	endfunction

	function automatic step_row_t mk(mode_t m, logic [31:0] v, logic [5:0] n,
			bit typed = 1'b0, status_t st = STS_OK, logic hv = 1'b0,
			logic [31:0] rv = '0, logic [5:0] lv = '0);
		step_row_t s;
		s.cmd   = '{mode: m, push_value: v, count: n};
		s.typed = typed;
		s.res   = '{value: rv, has_value: hv, status: st, last: 1'b1, level: lv};
		return s;
	endfunction

	// Stimulus: reset, directed table, then random commands in three idle phases.
	initial begin
		step_row_t row;
		int        idle_pct;
		int        total;
		int        n_dir;
		start  = 1'b0;
		cmd    = '0;
		arst_n = 1'b0;
		growing = 1'b1;
		shadow_fill = 0;
		directed_steps = '{
			// empty stack: underflows, empty group, short roll, unused mode
			mk(M_POP,    32'h0, 6'd0, 1, STS_UNDERFLOW, 0, 32'h0, 6'd0),
			mk(M_SWAP,   32'h0, 6'd0, 1, STS_UNDERFLOW, 0, 32'h0, 6'd0),
			mk(M_READN,  32'h0, 6'd0, 1, STS_OK,        0, 32'h0, 6'd0),
			mk(M_POPN,   32'h0, 6'd1, 1, STS_UNDERFLOW, 0, 32'h0, 6'd0),
			mk(M_ROLLUP, 32'h0, 6'd0, 1, STS_OK,        0, 32'h0, 6'd0),
			mk(mode_t'(4'd15), 32'h0, 6'd63, 1, STS_OK, 0, 32'h0, 6'd0),
			// extreme words, then peeks past the bottom
			mk(M_PUSH,   32'hFFFF_FFFF, 6'd0, 1, STS_OK, 0, 32'h0, 6'd1),
			mk(M_PUSH,   32'h0,         6'd0, 1, STS_OK, 0, 32'h0, 6'd2),
			mk(M_PEEK,   32'h0, 6'd1, 1, STS_OK,        1, 32'hFFFF_FFFF, 6'd2),
			mk(M_PEEK,   32'h0, 6'd2, 1, STS_UNDERFLOW, 0, 32'h0, 6'd2),
			mk(M_DUP,    32'h0, 6'd2, 1, STS_UNDERFLOW, 0, 32'h0, 6'd2),
			mk(M_DEL,    32'h0, 6'd2, 1, STS_UNDERFLOW, 0, 32'h0, 6'd2),
			// the rest goes through the shadow stack
			mk(M_PUSH,   32'hA5A5_5A5A, 6'd0),
			mk(M_PUSH,   32'h1234_5678, 6'd0),
			mk(M_SWAP,   32'h0, 6'd0),
			mk(M_DUP,    32'h0, 6'd3),
			mk(M_ROLLDN, 32'h0, 6'd5),
			mk(M_ROLLUP, 32'h0, 6'd3),
			mk(M_ROLLDN, 32'h0, 6'd1),
			mk(M_READN,  32'h0, 6'd5),
			mk(M_DEL,    32'h0, 6'd0),
			mk(M_POPN,   32'h0, 6'd32),
			mk(M_POPN,   32'h0, 6'd3),
			mk(mode_t'(4'd10), 32'hDEAD_BEEF, 6'd0),
			mk(M_POP,    32'h0, 6'd0)
		};
		n_dir = directed_steps.size();
		total = n_dir + RANDOM_ITEMS;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < total; k++) begin
			// sender idles 19% then 53% then not at all
			if (k < n_dir + RANDOM_ITEMS / 3)
				idle_pct = 19;
			else if (k < n_dir + 2 * RANDOM_ITEMS / 3)
				idle_pct = 53;
			else
				idle_pct = 0;
			while ($urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			if (k < n_dir) begin
				row = directed_steps[k];
			end else begin
				row.cmd   = random_cmd();
				row.typed = 1'b0;
			end
			start <= 1'b1;
			cmd   <= row.cmd;
			// transfer happens at the first edge with busy low
			do @(posedge clk); while (busy);
			stack_apply(row.cmd);
			if (row.typed)
				pending_results.insert(pending_results.size(), row.res);
			else
				foreach (new_results[i])
					pending_results.insert(pending_results.size(), new_results[i]);
		end
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result checker: the receiver never stalls, so every strobe is a transfer.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_strobe) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: %p", result);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.value !== want.value) begin
					$error("value: expected %h, got %h", want.value, result.value);
					mismatch_count++;
				end
				if (result.has_value !== want.has_value) begin
					$error("has_value: expected %b, got %b", want.has_value, result.has_value);
					mismatch_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatch_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, result.last);
					mismatch_count++;
				end
				if (result.level !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, result.level);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog; a 32-entry group read is the slowest command by far.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

@@ value_stack_with_pick_and_roll_core.f @@
sv/vstk_pkg.sv
sv/vstk_cell.sv
sv/value_stack_with_pick_and_roll_core.sv
dv/value_stack_with_pick_and_roll_core_tb.sv
